FILE: src/u8u16_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  // Width of the running unit counter; it saturates at its all-ones value.
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Width used when comparing the counter against the 16-bit capacity.
  localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

  // Result queue geometry.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOBUF   = 2'd3
  } status_t;

  typedef enum logic {
    CFG_BIG_ENDIAN = 1'b0,
    CFG_CAPACITY   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] code_unit;
    status_t     status;
    logic        last;
    logic [15:0] unit_count;
  } res_t;

  // Puts a code unit into the selected byte order.
  function automatic logic [15:0] order_unit(input logic [15:0] u, input logic be);
    order_unit = be ? {u[7:0], u[15:8]} : u;
  endfunction

endpackage

FILE: src/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder: input stage, decoder and result queue.
// A taken byte is registered in the input stage, then decoded and written into the result queue.
// Throughput: one input byte per cycle, back to back while in_ready is high. The output side drains
//   one beat per cycle while out_ready is high, keeping up even with surrogate pairs (four bytes each).
// Reset (rst_n low, synchronous): decoder state, unit counter and result queue clear,
//   cfg_be_r returns to 0 and cfg_cap_r to 65535.
module utf8_to_utf16_transcoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input byte channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [15:0] out_unit_count
);
  import u8u16_pkg::*;

  // Configuration registers.
  logic        cfg_be_r;
  logic [15:0] cfg_cap_r;

  // Input stage: the accepted byte is registered here before it is decoded. The stage never stalls,
  // because a byte is only taken while the queue can absorb both it and the staged one.
  logic       stg_vld_r;
  logic [7:0] stg_byte_r;

  // Decoder state.
  logic [20:0]           acc_r, acc_nxt;
  logic [1:0]            bl_r, bl_nxt;
  logic [2:0]            len_r, len_nxt;
  logic [COUNT_BITS-1:0] units_r, units_nxt;
  logic                  disc_r, disc_nxt;

  // Results of the staged byte.
  res_t       r0, r1;
  logic [1:0] n_push;

  // Result queue.
  res_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] q_wr_r, q_rd_r, q_wr_p1;
  logic [QCNT_W-1:0] q_cnt_r;
  logic              pop;
  logic [QCNT_W:0]   room_sum;

  // A byte completes a code point when it is a plain ASCII byte or the final
  // continuation byte of a longer sequence.
  logic [7:0]  b;
  logic [20:0] acc_shift;
  logic        fin_go;
  logic [20:0] fin_cp;
  logic [2:0]  fin_len;

  // Checks on a completed code point, in the order the format requires.
  logic                  fin_overlong, fin_range, fin_two, fin_nobuf, fin_surr;
  logic [CMP_W-1:0]      fin_sum;
  logic [20:0]           sup_off;
  logic [15:0]           hi_unit, lo_unit;
  logic [COUNT_BITS:0]   bump_sum;
  logic [COUNT_BITS-1:0] units_bumped;
  logic                  term_nobuf;

  assign in_ready = (room_sum <= (QCNT_W+1)'(QDEPTH - 2));
  assign room_sum = {1'b0, q_cnt_r} + (QCNT_W+1)'({stg_vld_r, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_be_r  <= 1'b0;
      cfg_cap_r <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BIG_ENDIAN: cfg_be_r  <= cfg_wdata[0];
        CFG_CAPACITY:   cfg_cap_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_byte;
    end
  end

  assign b         = stg_byte_r;
  assign acc_shift = {acc_r[14:0], b[5:0]};

  always_comb begin
    fin_go  = 1'b0;
    fin_cp  = acc_shift;
    fin_len = len_r;
    if (!disc_r) begin
      if (bl_r != 2'd0) begin
        fin_go = (b != 8'h00) && (b[7:6] == 2'b10) && (bl_r == 2'd1);
      end else if ((b != 8'h00) && !b[7]) begin
        fin_go  = 1'b1;
        fin_cp  = 21'(b);
        fin_len = 3'd1;
      end
    end
  end

  assign fin_overlong = ((fin_len == 3'd2) && (fin_cp < 21'h000080)) ||
                        ((fin_len == 3'd3) && (fin_cp < 21'h000800)) ||
                        ((fin_len == 3'd4) && (fin_cp < 21'h010000));
  assign fin_range    = fin_cp > 21'h10FFFF;
  assign fin_two      = fin_cp > 21'h00FFFF;
  // Room is needed for the new units plus one unit kept for the terminator.
  assign fin_sum      = CMP_W'(units_r) + (fin_two ? CMP_W'(3) : CMP_W'(2));
  assign fin_nobuf    = fin_sum > CMP_W'(cfg_cap_r);
  assign fin_surr     = (fin_cp >= 21'h00D800) && (fin_cp <= 21'h00DFFF);
  assign sup_off      = fin_cp - 21'h010000;
  assign hi_unit      = 16'hD800 | 16'(sup_off[19:10]);
  assign lo_unit      = 16'hDC00 | 16'(sup_off[9:0]);
  assign bump_sum     = {1'b0, units_r} + (fin_two ? (COUNT_BITS+1)'(2) : (COUNT_BITS+1)'(1));
  assign units_bumped = (bump_sum > {1'b0, CNT_MAX}) ? CNT_MAX : bump_sum[COUNT_BITS-1:0];
  assign term_nobuf   = CMP_W'(units_r) >= CMP_W'(cfg_cap_r);

  always_comb begin
    acc_nxt   = acc_r;
    bl_nxt    = bl_r;
    len_nxt   = len_r;
    units_nxt = units_r;
    disc_nxt  = disc_r;
    n_push    = 2'd0;
    r0        = '0;
    r1        = '0;
    if (stg_vld_r) begin
      priority if (disc_r) begin
        // Bytes after an error are dropped; the zero byte ends the string.
        if (b == 8'h00) begin
          disc_nxt  = 1'b0;
          acc_nxt   = '0;
          bl_nxt    = '0;
          len_nxt   = '0;
          units_nxt = '0;
        end
      end else if (bl_r != 2'd0) begin
        if ((b == 8'h00) || (b[7:6] != 2'b10)) begin
          // A zero inside a sequence ends the string, so nothing is dropped after it.
          r0.status = ST_INVALID;
          r0.last   = 1'b1;
          n_push    = 2'd1;
          acc_nxt   = '0;
          bl_nxt    = '0;
          len_nxt   = '0;
          units_nxt = '0;
          disc_nxt  = (b != 8'h00);
        end else begin
          acc_nxt = acc_shift;
          bl_nxt  = bl_r - 2'd1;
        end
      end else if (b == 8'h00) begin
        acc_nxt   = '0;
        bl_nxt    = '0;
        len_nxt   = '0;
        units_nxt = '0;
        r0.last   = 1'b1;
        n_push    = 2'd1;
        if (term_nobuf) begin
          r0.status = ST_NOBUF;
        end else begin
          r0.status     = ST_OK;
          r0.unit_count = 16'(units_r);
        end
      end else if (!b[7]) begin
        // Plain ASCII is handled by the completion logic below.
      end else if (b[7:5] == 3'b110) begin
        acc_nxt = 21'(b[4:0]);
        len_nxt = 3'd2;
        bl_nxt  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_nxt = 21'(b[3:0]);
        len_nxt = 3'd3;
        bl_nxt  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc_nxt = 21'(b[2:0]);
        len_nxt = 3'd4;
        bl_nxt  = 2'd3;
      end else begin
        r0.status = ST_INVALID;
        r0.last   = 1'b1;
        n_push    = 2'd1;
        acc_nxt   = '0;
        bl_nxt    = '0;
        len_nxt   = '0;
        units_nxt = '0;
        disc_nxt  = 1'b1;
      end

      if (fin_go) begin
        acc_nxt = '0;
        bl_nxt  = '0;
        len_nxt = '0;
        n_push  = 2'd1;
        priority if (fin_overlong || fin_range || fin_nobuf || fin_surr) begin
          r0.last   = 1'b1;
          units_nxt = '0;
          disc_nxt  = 1'b1;
          priority if (fin_overlong) r0.status = ST_INVALID;
          else if (fin_range)        r0.status = ST_RANGE;
          else if (fin_nobuf)        r0.status = ST_NOBUF;
          else                       r0.status = ST_INVALID;
        end else if (fin_two) begin
          r0.code_unit = order_unit(hi_unit, cfg_be_r);
          r1.code_unit = order_unit(lo_unit, cfg_be_r);
          n_push       = 2'd2;
          units_nxt    = units_bumped;
        end else begin
          r0.code_unit = order_unit(fin_cp[15:0], cfg_be_r);
          units_nxt    = units_bumped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      bl_r    <= '0;
      len_r   <= '0;
      units_r <= '0;
      disc_r  <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      bl_r    <= bl_nxt;
      len_r   <= len_nxt;
      units_r <= units_nxt;
      disc_r  <= disc_nxt;
    end
  end

  // Result queue: up to two beats written per cycle, one beat read per cycle while out_ready is high.
  assign pop     = out_valid && out_ready;
  assign q_wr_p1 = q_wr_r + QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + QPTR_W'(n_push);
      q_rd_r  <= q_rd_r + QPTR_W'(pop);
      q_cnt_r <= q_cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem_r[q_wr_r] <= r0;
    end
    if (n_push == 2'd2) begin
      q_mem_r[q_wr_p1] <= r1;
    end
  end

  assign out_valid      = q_cnt_r != '0;
  assign out_code_unit  = q_mem_r[q_rd_r].code_unit;
  assign out_status     = q_mem_r[q_rd_r].status;
  assign out_last       = q_mem_r[q_rd_r].last;
  assign out_unit_count = q_mem_r[q_rd_r].unit_count;

  // The admission rule must leave room for every beat the staged byte produces.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (QCNT_W+1)'(q_cnt_r) + (QCNT_W+1)'(n_push) <= (QCNT_W+1)'(QDEPTH))
    else $error("result queue overflow");

  // With no sequence open, the sequence length is cleared.
  a_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (bl_r == 2'd0) |-> (len_r == 3'd0))
    else $error("sequence length left over with no bytes pending");

  // While a sequence is open, fewer continuation bytes remain than its length.
  a_seq_open: assert property (@(posedge clk) disable iff (!rst_n)
    (bl_r != 2'd0) |-> ((len_r >= 3'd2) && (len_r <= 3'd4) && (3'(bl_r) < len_r)))
    else $error("inconsistent open sequence");

  // A surrogate pair is made only of two plain data beats.
  a_pair_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push == 2'd2) |-> ((r0.status == ST_OK) && (r1.status == ST_OK) && !r0.last && !r1.last))
    else $error("surrogate pair carries an error or end flag");

  // Dropped bytes never produce beats.
  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && disc_r) |-> (n_push == 2'd0))
    else $error("beat produced while dropping bytes");

endmodule

FILE: dv/utf16_stream_checker.sv
// Checker for the UTF-8 to UTF-16 transcoder: models the decoder and scores every result beat.
module utf16_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_code_unit,
  input  logic [1:0]  out_status,
  input  logic        out_last,
  input  logic [15:0] out_unit_count,
  output int          error_count,
  output int          beats_owed
);
  import u8u16_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Mirror of the configuration registers.
  logic                  swap_bytes;
  logic [15:0]           capacity;

  // Mirror of the decoder state.
  logic [20:0]           cp_bits;
  logic [1:0]            cont_left;
  logic [2:0]            seq_len;
  logic [COUNT_BITS-1:0] units_done;
  logic                  dropping;

  res_t utf16_q[$];
  int   reports;

  function automatic logic [15:0] as_sent(input logic [15:0] u);
    return swap_bytes ? {u[7:0], u[15:8]} : u;
  endfunction

  function automatic res_t make_beat(input logic [15:0] u, input status_t st,
                                     input logic lst, input logic [15:0] cnt);
    res_t r;
    r.code_unit  = u;
    r.status     = st;
    r.last       = lst;
    r.unit_count = cnt;
    return r;
  endfunction

  task automatic clear_seq();
    cp_bits   = '0;
    cont_left = '0;
    seq_len   = '0;
  endtask

  // An error beat ends the string unless the zero byte already did.
  task automatic raise_error(input status_t st, input logic ended);
    utf16_q.push_back(make_beat(16'h0000, st, 1'b1, 16'h0000));
    clear_seq();
    units_done = '0;
    dropping   = !ended;
  endtask

  task automatic bump_count(input int n);
    longint t;
    t = longint'(units_done) + n;
    if (t > longint'(CNT_MAX)) begin
      units_done = CNT_MAX;
    end else begin
      units_done = COUNT_BITS'(t);
    end
  endtask

  task automatic complete_code_point(input logic [20:0] cp, input logic [2:0] len);
    int          need;
    logic [20:0] off;
    need = (cp <= 21'h00FFFF) ? 1 : 2;
    if ((len == 3'd2 && cp < 21'h80) || (len == 3'd3 && cp < 21'h800) ||
        (len == 3'd4 && cp < 21'h10000)) begin
      raise_error(ST_INVALID, 1'b0);
    end else if (cp > 21'h10FFFF) begin
      raise_error(ST_RANGE, 1'b0);
    end else if (longint'(units_done) + need + 1 > longint'(capacity)) begin
      raise_error(ST_NOBUF, 1'b0);
    end else if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
      raise_error(ST_INVALID, 1'b0);
    end else begin
      clear_seq();
      if (need == 1) begin
        utf16_q.push_back(make_beat(as_sent(cp[15:0]), ST_OK, 1'b0, 16'h0000));
      end else begin
        off = cp - 21'h10000;
        utf16_q.push_back(make_beat(as_sent(16'hD800 | {6'd0, off[19:10]}), ST_OK, 1'b0,
                                    16'h0000));
        utf16_q.push_back(make_beat(as_sent(16'hDC00 | {6'd0, off[9:0]}), ST_OK, 1'b0,
                                    16'h0000));
      end
      bump_count(need);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (dropping) begin
      // Bytes after an error are swallowed; the zero byte silently restarts.
      if (b == 8'h00) begin
        dropping = 1'b0;
        clear_seq();
        units_done = '0;
      end
    end else if (cont_left != 2'd0) begin
      if (b == 8'h00) begin
        raise_error(ST_INVALID, 1'b1);
      end else if (b[7:6] != 2'b10) begin
        raise_error(ST_INVALID, 1'b0);
      end else begin
        cp_bits   = {cp_bits[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          complete_code_point(cp_bits, seq_len);
        end
      end
    end else if (b == 8'h00) begin
      if (units_done >= capacity) begin
        utf16_q.push_back(make_beat(16'h0000, ST_NOBUF, 1'b1, 16'h0000));
      end else begin
        utf16_q.push_back(make_beat(16'h0000, ST_OK, 1'b1, 16'(units_done)));
      end
      clear_seq();
      units_done = '0;
    end else if (!b[7]) begin
      complete_code_point({13'd0, b}, 3'd1);
    end else if (b[7:5] == 3'b110) begin
      cp_bits   = {16'd0, b[4:0]};
      seq_len   = 3'd2;
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_bits   = {17'd0, b[3:0]};
      seq_len   = 3'd3;
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_bits   = {18'd0, b[2:0]};
      seq_len   = 3'd4;
      cont_left = 2'd3;
    end else begin
      raise_error(ST_INVALID, 1'b0);
    end
  endtask

  task automatic score_beat();
    res_t want;
    if (utf16_q.size() == 0) begin
      error_count++;
      if (reports < REPORT_LIMIT) begin
        reports++;
        $display("unexpected beat: unit %h st %0d last %b cnt %0d", out_code_unit,
                 out_status, out_last, out_unit_count);
      end
    end else begin
      want = utf16_q.pop_front();
      if (want.code_unit != out_code_unit || want.status != out_status ||
          want.last != out_last || want.unit_count != out_unit_count) begin
        error_count++;
        if (reports < REPORT_LIMIT) begin
          reports++;
          $display("mismatch: exp unit %h st %0d last %b cnt %0d",
                   want.code_unit, want.status, want.last, want.unit_count);
          $display("          got unit %h st %0d last %b cnt %0d",
                   out_code_unit, out_status, out_last, out_unit_count);
        end
      end
    end
  endtask

  initial begin
    error_count = 0;
    beats_owed  = 0;
    reports     = 0;
  end

  // A beat leaving at an edge always belongs to a byte taken at an earlier edge,
  // so the output side is scored before the input side is modeled.
  always @(posedge clk) begin
    if (!rst_n) begin
      swap_bytes = 1'b0;
      capacity   = 16'hFFFF;
      clear_seq();
      units_done = '0;
      dropping   = 1'b0;
      utf16_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        score_beat();
      end
      if (in_valid && in_ready) begin
        decode_byte(in_byte);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_BIG_ENDIAN) begin
          swap_bytes = cfg_wdata[0];
        end else begin
          capacity = cfg_wdata;
        end
      end
    end
    beats_owed = utf16_q.size();
  end

endmodule

FILE: dv/utf8_to_utf16_transcoder_top_tb.sv
// Testbench top for the UTF-8 to UTF-16 transcoder: stimulus, idling, watchdog and verdict.
module utf8_to_utf16_transcoder_top_tb;
  import u8u16_pkg::*;

  // The longest correct quiet stretch is the deliberate receiver hold-off;
  // the watchdog limit leaves several times that.
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 16;

  // Directed strings: the top code point with an ASCII extreme, a 0xFF lead,
  // a stray continuation used as lead with a dropped byte after it, a broken
  // continuation, a zero cutting a sequence short, an overlong pair, a value
  // above U+10FFFF and an encoded surrogate.
  localparam logic [7:0] DIRECTED [0:27] = '{
    8'h7F, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
    8'hFF, 8'h00,
    8'h80, 8'h55, 8'h00,
    8'hC2, 8'h41, 8'h00,
    8'hE0, 8'h00,
    8'hC1, 8'hBF, 8'h00,
    8'hF4, 8'h90, 8'h80, 8'h80, 8'h00,
    8'hED, 8'hA0, 8'h80, 8'h00
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_code_unit;
  logic [1:0]  out_status;
  logic        out_last;
  logic [15:0] out_unit_count;

  int error_count;
  int beats_owed;

  // Idling knobs, set per phase: percent chance of an idle burst on each side.
  int tx_gap_pct;
  int rx_stall_pct;
  // Asks the receiver for one long hold-off.
  bit hold_req;
  int quiet_cycles;

  logic [7:0] utf8_q[$];

  utf8_to_utf16_transcoder_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_unit  (out_code_unit),
    .out_status     (out_status),
    .out_last       (out_last),
    .out_unit_count (out_unit_count)
  );

  utf16_stream_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_unit  (out_code_unit),
    .out_status     (out_status),
    .out_last       (out_last),
    .out_unit_count (out_unit_count),
    .error_count    (error_count),
    .beats_owed     (beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any edge that moves a beat on either channel resets the count.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("utf8_to_utf16_transcoder_top_tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver. It changes out_ready only at falling edges. A hold-off request
  // keeps it low for a long stretch so the result queue fills and the block
  // has to push back on its input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offers one byte, possibly after a short gap, and returns at the rising
  // edge that takes the beat. in_ready is read there before the block updates.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sends the whole byte queue, then drops valid at the very next falling
  // edge so the last beat is not taken twice.
  task automatic send_all();
    foreach (utf8_q[i]) begin
      send_byte(utf8_q[i]);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Waits until every predicted beat has come out, then lets the decoder settle;
  // bytes that give no beat may still be in flight in the input stage.
  task automatic drain_results();
    do @(negedge clk); while (beats_owed != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic add_cont();
    utf8_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endtask

  // Minimal UTF-8 form of a code point.
  task automatic add_code_point(input int unsigned cp);
    if (cp < 'h80) begin
      utf8_q.push_back(8'(cp));
    end else if (cp < 'h800) begin
      utf8_q.push_back(8'('hC0 | (cp >> 6)));
      utf8_q.push_back(8'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      utf8_q.push_back(8'('hE0 | (cp >> 12)));
      utf8_q.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
      utf8_q.push_back(8'('h80 | (cp & 'h3F)));
    end else begin
      utf8_q.push_back(8'('hF0 | (cp >> 18)));
      utf8_q.push_back(8'('h80 | ((cp >> 12) & 'h3F)));
      utf8_q.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
      utf8_q.push_back(8'('h80 | (cp & 'h3F)));
    end
  endtask

  // A random well-formed character from one of the four length classes.
  // Surrogate values are shifted down into the plain BMP range below them.
  task automatic add_valid_char();
    int unsigned cp;
    case ($urandom_range(0, 3))
      0: cp = $urandom_range(1, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: begin
        cp = $urandom_range('h800, 'hFFFF);
        if (cp >= 'hD800 && cp <= 'hDFFF) begin
          cp = cp - 'h800;
        end
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    add_code_point(cp);
  endtask

  // One malformed sequence. ended is set when a zero byte cut it short,
  // because that zero already closes the string.
  task automatic add_broken_seq(output bit ended);
    int len;
    ended = 1'b0;
    case ($urandom_range(0, 5))
      0: begin
        // Lead byte that cannot open a sequence.
        if ($urandom_range(0, 1)) begin
          utf8_q.push_back(8'($urandom_range('h80, 'hBF)));
        end else begin
          utf8_q.push_back(8'($urandom_range('hF8, 'hFF)));
        end
      end
      1, 2: begin
        // Sequence interrupted by a non-continuation byte or by a zero.
        len = $urandom_range(2, 4);
        case (len)
          2:       utf8_q.push_back(8'($urandom_range('hC0, 'hDF)));
          3:       utf8_q.push_back(8'($urandom_range('hE0, 'hEF)));
          default: utf8_q.push_back(8'($urandom_range('hF0, 'hF7)));
        endcase
        repeat ($urandom_range(0, len - 2)) add_cont();
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 1)) begin
            utf8_q.push_back(8'($urandom_range(1, 'h7F)));
          end else begin
            utf8_q.push_back(8'($urandom_range('hC0, 'hFF)));
          end
        end else begin
          utf8_q.push_back(8'h00);
          ended = 1'b1;
        end
      end
      3: begin
        // Overlong encodings of each length.
        case ($urandom_range(2, 4))
          2: begin
            utf8_q.push_back(8'($urandom_range('hC0, 'hC1)));
            add_cont();
          end
          3: begin
            utf8_q.push_back(8'hE0);
            utf8_q.push_back(8'h80 | 8'($urandom_range(0, 31)));
            add_cont();
          end
          default: begin
            utf8_q.push_back(8'hF0);
            utf8_q.push_back(8'h80 | 8'($urandom_range(0, 15)));
            add_cont();
            add_cont();
          end
        endcase
      end
      4: begin
        // Four-byte values past U+10FFFF.
        if ($urandom_range(0, 1)) begin
          utf8_q.push_back(8'hF4);
          utf8_q.push_back(8'($urandom_range('h90, 'hBF)));
        end else begin
          utf8_q.push_back(8'($urandom_range('hF5, 'hF7)));
          add_cont();
        end
        add_cont();
        add_cont();
      end
      default: begin
        // Encoded surrogate code point.
        utf8_q.push_back(8'hED);
        utf8_q.push_back(8'($urandom_range('hA0, 'hBF)));
        add_cont();
      end
    endcase
  endtask

  // One zero-terminated string: mostly well-formed characters, sometimes with
  // one broken sequence plus junk that the block must drop, now and then pure
  // noise.
  task automatic add_string();
    int n;
    int at;
    bit broken;
    bit ended;
    ended = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) utf8_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      n      = $urandom_range(0, 6);
      at     = $urandom_range(0, n);
      broken = ($urandom_range(0, 99) < 30);
      for (int i = 0; i <= n; i++) begin
        if (broken && i == at) begin
          add_broken_seq(ended);
          if (!ended) begin
            repeat ($urandom_range(0, 3)) utf8_q.push_back(8'($urandom_range(1, 255)));
          end
          break;
        end
        if (i < n) begin
          add_valid_char();
        end
      end
    end
    if (!ended) begin
      utf8_q.push_back(8'h00);
    end
  endtask

  // One random phase: wait for the block to go idle, program both registers,
  // then stream whole strings under the given idling.
  task automatic run_phase(input logic be, input logic [15:0] cap, input int nbytes,
                           input int gap_pct, input int stall_pct, input bit hold);
    drain_results();
    write_reg(CFG_BIG_ENDIAN, {15'($urandom), be});
    write_reg(CFG_CAPACITY, cap);
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    utf8_q.delete();
    while (utf8_q.size() < nbytes) begin
      add_string();
    end
    hold_req = hold;
    send_all();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_BIG_ENDIAN;
    cfg_wdata    = 16'h0000;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed strings run with the reset configuration: native order and
    // full capacity.
    utf8_q.delete();
    foreach (DIRECTED[i]) begin
      utf8_q.push_back(DIRECTED[i]);
    end
    send_all();

    // Random phases sweep byte order and capacity, the extremes included.
    // A capacity of one leaves room for the terminator alone, so every
    // character overflows; small capacities hit the boundary often.
    run_phase(1'b0, 16'hFFFF, 100, 20, 20, 1'b0);
    run_phase(1'b1, 16'hFFFF, 100, 0, 30, 1'b1);
    run_phase(1'b1, 16'd1, 60, 30, 0, 1'b0);
    run_phase(1'b0, 16'd3, 80, 10, 40, 1'b0);
    run_phase(1'b1, 16'($urandom_range(4, 12)), 100, 15, 15, 1'b0);
    run_phase(1'b0, 16'($urandom_range(1, 65535)), 90, 25, 10, 1'b0);
    // Last stretch runs back to back with no idling on either side.
    run_phase(1'b1, 16'hFFFF, 120, 0, 0, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("utf8_to_utf16_transcoder_top_tb: PASS");
    end else begin
      $display("utf8_to_utf16_transcoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
